### rtl/cca_pkg.sv
package cca_pkg;

  localparam logic [15:0] BCAST_DEST = 16'hFFFF;
  localparam int unsigned HEADER_BYTES = 15;
  localparam logic        OP_TICK = 1'b0;
  localparam logic        OP_SEND = 1'b1;

  typedef enum logic [2:0] {
    EV_TX_START    = 3'd0,
    EV_ACCESS_FAIL = 3'd1,
    EV_RELEASE     = 3'd2,
    EV_TOO_LONG    = 3'd3,
    EV_FULL        = 3'd4,
    EV_RADIO_OFF   = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    REG_MIN_BE         = 3'd0,
    REG_MAX_BE         = 3'd1,
    REG_MAX_RETRIES    = 3'd2,
    REG_CCA_TICKS      = 3'd3,
    REG_UNIT_TICKS     = 3'd4,
    REG_TICKS_PER_BYTE = 3'd5,
    REG_MAX_PAYLOAD    = 3'd6,
    REG_RADIO_ON       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  payload_bytes;
    logic [15:0] dest_addr;
    logic        broadcast;
    logic        channel_idle;
    logic [7:0]  random_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] frame_dest;
    logic [8:0]  frame_bytes;
    logic [3:0]  busy_count;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic [15:0] dest;
    logic [8:0]  bytes;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } fifo_ctl_t;

endpackage

### rtl/cca_stream_if.sv
interface cca_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/cca_ram.sv
module cca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/cca_fifo.sv
// Frame queue with the head shown first-word-fall-through; a write to the
// address being read in the same cycle is forwarded around the RAM.
module cca_fifo #(
  parameter int unsigned Depth = 8,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned LvlW = $clog2(Depth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cca_pkg::fifo_ctl_t ctl_i,
  input  cca_pkg::frame_t   wdata_i,
  output cca_pkg::frame_t   head_o,
  output logic [LvlW-1:0]   level_o
);

  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LvlW-1:0] level_q, level_d;
  logic            fwd_valid_q, fwd_valid_d;
  cca_pkg::frame_t fwd_q, ram_rdata;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (ctl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      level_d = '0;
    end else begin
      if (ctl_i.push) begin
        tail_d  = ptr_inc(tail_q);
        level_d = level_q + LvlW'(1);
      end
      if (ctl_i.pop) begin
        head_d  = ptr_inc(head_q);
        level_d = level_q - LvlW'(1);
      end
    end
    fwd_valid_d = ctl_i.push && !ctl_i.flush && (tail_q == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      level_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      level_q     <= level_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wdata_i;
  end

  cca_ram #(
    .Width ($bits(cca_pkg::frame_t)),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push && !ctl_i.flush),
    .waddr_i (tail_q),
    .wdata_i (wdata_i),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign head_o  = fwd_valid_q ? fwd_q : ram_rdata;
  assign level_o = level_q;

endmodule

### rtl/csma_ca_tx_controller_core.sv
// An accepted item is held in the input register and processed when the
// output can take it; its result, if any, is registered at the output.
// Throughput: one item per cycle unless output stalls; frame queue head is
// a RAM with registered read port and write-forward path; pops do not stall.
// Reset (async, active low): config registers to defaults, controller idle,
// queue empty; queue RAM contents are left undefined, no clearing pass.
module csma_ca_tx_controller_core #(
  parameter int unsigned FIFO_DEPTH = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cca_stream_if.sink   in_i,
  cca_stream_if.source out_o,
  cca_stream_if.sink   cfg_i
);

  localparam int unsigned LvlW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BACKOFF,
    PH_CCA,
    PH_TX
  } phase_e;

  // configuration
  logic [3:0] min_be_q, max_be_q;
  logic [2:0] max_retries_q;
  logic [7:0] cca_ticks_q, unit_ticks_q, max_payload_q;
  logic [3:0] tpb_q;
  logic       radio_on_q;

  // controller state
  phase_e          phase_q, phase_d;
  logic [3:0]      busy_q, busy_d;
  logic [3:0]      be_q, be_d;
  logic [15:0]     wait_q, wait_d;
  cca_pkg::frame_t cur_q, cur_d;

  // pipeline registers
  logic                in_valid_q;
  cca_pkg::in_item_t   in_q;
  logic                out_valid_q, out_valid_d;
  cca_pkg::out_item_t  out_q, out_d;

  logic                advance, cfg_wr, flush;
  cca_pkg::fifo_ctl_t  fifo_ctl;
  cca_pkg::frame_t     frame_req, fifo_head;
  logic [LvlW-1:0]     fifo_level;

  logic        res_valid, draw, start_next;
  logic [3:0]  draw_be, busy_inc;
  logic [4:0]  be_inc5;
  logic [3:0]  be_inc;
  logic [7:0]  mask;
  logic [15:0] backoff, cca_wait, air, wait_dec;

  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;
  assign cfg_wr = cfg_i.valid;
  assign flush = cfg_wr && (cca_pkg::reg_idx_e'(cfg_i.payload.index) == cca_pkg::REG_RADIO_ON)
                 && !cfg_i.payload.data[0];

  assign frame_req.dest  = in_q.broadcast ? cca_pkg::BCAST_DEST : in_q.dest_addr;
  assign frame_req.bytes = 9'(cca_pkg::HEADER_BYTES) + 9'(in_q.payload_bytes);

  assign cca_wait = (cca_ticks_q == 8'd0) ? 16'd1 : 16'(cca_ticks_q);
  assign air      = 16'(cur_q.bytes * 13'(tpb_q));
  assign wait_dec = (wait_q != 16'd0) ? wait_q - 16'd1 : wait_q;
  assign be_inc5  = 5'(be_q) + 5'd1;
  assign be_inc   = (be_inc5 > 5'(max_be_q)) ? max_be_q : be_inc5[3:0];
  assign busy_inc = busy_q + 4'd1;

  assign mask    = (draw_be >= 4'd8) ? 8'hFF : ((8'd1 << draw_be[2:0]) - 8'd1);
  assign backoff = 16'(in_q.random_bits & mask) * 16'(unit_ticks_q);

  always_comb begin
    phase_d    = phase_q;
    busy_d     = busy_q;
    be_d       = be_q;
    wait_d     = wait_q;
    cur_d      = cur_q;
    fifo_ctl   = '0;
    res_valid  = 1'b0;
    out_d      = out_q;
    draw       = 1'b0;
    draw_be    = min_be_q;
    start_next = 1'b0;

    if (advance) begin
      if (in_q.opcode == cca_pkg::OP_SEND) begin
        out_d.frame_dest  = frame_req.dest;
        out_d.frame_bytes = frame_req.bytes;
        out_d.busy_count  = 4'd0;
        priority if (!radio_on_q) begin
          res_valid       = 1'b1;
          out_d.event_res = cca_pkg::EV_RADIO_OFF;
        end else if (in_q.payload_bytes > max_payload_q) begin
          res_valid       = 1'b1;
          out_d.event_res = cca_pkg::EV_TOO_LONG;
        end else if (phase_q == PH_IDLE) begin
          cur_d  = frame_req;
          busy_d = 4'd0;
          be_d   = min_be_q;
          draw   = 1'b1;
        end else if (fifo_level >= LvlW'(FIFO_DEPTH)) begin
          res_valid       = 1'b1;
          out_d.event_res = cca_pkg::EV_FULL;
        end else begin
          fifo_ctl.push = 1'b1;
        end
      end else if (phase_q != PH_IDLE) begin
        wait_d = wait_dec;
        if (wait_dec == 16'd0) begin
          out_d.frame_dest  = cur_q.dest;
          out_d.frame_bytes = cur_q.bytes;
          out_d.busy_count  = busy_q;
          unique case (phase_q)
            PH_IDLE: ;
            PH_BACKOFF: begin
              phase_d = PH_CCA;
              wait_d  = cca_wait;
            end
            PH_CCA: begin
              if (in_q.channel_idle) begin
                res_valid       = 1'b1;
                out_d.event_res = cca_pkg::EV_TX_START;
                phase_d         = PH_TX;
                wait_d          = (air == 16'd0) ? 16'd1 : air;
              end else begin
                be_d   = be_inc;
                busy_d = busy_inc;
                if (busy_inc <= 4'(max_retries_q)) begin
                  draw    = 1'b1;
                  draw_be = be_inc;
                end else begin
                  res_valid        = 1'b1;
                  out_d.event_res  = cca_pkg::EV_ACCESS_FAIL;
                  out_d.busy_count = busy_inc;
                  start_next       = 1'b1;
                end
              end
            end
            PH_TX: begin
              res_valid       = 1'b1;
              out_d.event_res = cca_pkg::EV_RELEASE;
              start_next      = 1'b1;
            end
          endcase
        end
      end
    end

    if (start_next) begin
      if (fifo_level == '0) begin
        phase_d = PH_IDLE;
        wait_d  = 16'd0;
        cur_d   = '0;
      end else begin
        fifo_ctl.pop = 1'b1;
        cur_d        = fifo_head;
        busy_d       = 4'd0;
        be_d         = min_be_q;
        draw         = 1'b1;
        draw_be      = min_be_q;
      end
    end

    // zero backoff goes straight to CCA without spending a tick
    if (draw) begin
      if (backoff == 16'd0) begin
        phase_d = PH_CCA;
        wait_d  = cca_wait;
      end else begin
        phase_d = PH_BACKOFF;
        wait_d  = backoff;
      end
    end

    if (flush) begin
      phase_d        = PH_IDLE;
      busy_d         = 4'd0;
      be_d           = 4'd0;
      wait_d         = 16'd0;
      cur_d          = '0;
      fifo_ctl.flush = 1'b1;
    end

    priority if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  cca_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fifo_ctl),
    .wdata_i (frame_req),
    .head_o  (fifo_head),
    .level_o (fifo_level)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_be_q      <= 4'd3;
      max_be_q      <= 4'd5;
      max_retries_q <= 3'd4;
      cca_ticks_q   <= 8'd8;
      unit_ticks_q  <= 8'd20;
      tpb_q         <= 4'd2;
      max_payload_q <= 8'd100;
      radio_on_q    <= 1'b1;
      phase_q       <= PH_IDLE;
      busy_q        <= 4'd0;
      be_q          <= 4'd0;
      wait_q        <= 16'd0;
      cur_q         <= '0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cca_pkg::reg_idx_e'(cfg_i.payload.index))
          cca_pkg::REG_MIN_BE:         min_be_q      <= cfg_i.payload.data[3:0];
          cca_pkg::REG_MAX_BE:         max_be_q      <= cfg_i.payload.data[3:0];
          cca_pkg::REG_MAX_RETRIES:    max_retries_q <= cfg_i.payload.data[2:0];
          cca_pkg::REG_CCA_TICKS:      cca_ticks_q   <= cfg_i.payload.data;
          cca_pkg::REG_UNIT_TICKS:     unit_ticks_q  <= cfg_i.payload.data;
          cca_pkg::REG_TICKS_PER_BYTE: tpb_q         <= cfg_i.payload.data[3:0];
          cca_pkg::REG_MAX_PAYLOAD:    max_payload_q <= cfg_i.payload.data;
          cca_pkg::REG_RADIO_ON:       radio_on_q    <= cfg_i.payload.data[0];
        endcase
      end
      phase_q     <= phase_d;
      busy_q      <= busy_d;
      be_q        <= be_d;
      wait_q      <= wait_d;
      cur_q       <= cur_d;
      in_valid_q  <= in_i.ready ? in_i.valid : in_valid_q;
      out_valid_q <= out_valid_d;
      if (res_valid) begin
        out_q <= out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // an idle controller never holds queued frames
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (fifo_level == '0))
    else $error("frames queued while idle");

  // every active phase has a pending countdown
  a_wait_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (wait_q != 16'd0))
    else $error("active phase with zero wait count");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= LvlW'(FIFO_DEPTH))
    else $error("queue level above depth");

  // a held result must not be overwritten by a new one
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !res_valid)
    else $error("result produced while output stalled");

endmodule

### dv/testbench.sv
module testbench;

  localparam int unsigned QUEUE_DEPTH    = 8;
  localparam int unsigned LATENCY_CYCLES = 4;
  localparam int unsigned TARGET_ITEMS   = 1750;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BACKOFF,
    ST_CCA,
    ST_TX
  } csma_state_e;

  typedef logic [7:0] reg_set_t [8];

  logic clk_i;
  logic rst_ni;

  cca_stream_if #(.payload_t(cca_pkg::in_item_t))  in_if ();
  cca_stream_if #(.payload_t(cca_pkg::out_item_t)) out_if ();
  cca_stream_if #(.payload_t(cca_pkg::cfg_item_t)) cfg_if ();

  csma_ca_tx_controller_core #(
    .FIFO_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow of the controller: configuration, channel access state, frame queue
  logic [3:0]  cfg_min_be;
  logic [3:0]  cfg_max_be;
  logic [2:0]  cfg_retries;
  logic [7:0]  cfg_cca;
  logic [7:0]  cfg_unit;
  logic [3:0]  cfg_tpb;
  logic [7:0]  cfg_max_payload;
  logic        cfg_radio;

  csma_state_e        st;
  logic [3:0]         busy_cnt;
  logic [3:0]         be;
  logic [15:0]        wait_cnt;
  cca_pkg::frame_t    cur_frame;
  cca_pkg::frame_t    pending_frames[$];
  cca_pkg::out_item_t expected_events[$];

  bit          no_idle = 1'b0;
  int unsigned error_count = 0;

  function automatic void push_event(cca_pkg::event_e ev, cca_pkg::frame_t f,
                                     logic [3:0] busy);
    cca_pkg::out_item_t r;
    r.event_res   = ev;
    r.frame_dest  = f.dest;
    r.frame_bytes = f.bytes;
    r.busy_count  = busy;
    expected_events.push_back(r);
  endfunction

  function automatic void flush_frames();
    st       = ST_IDLE;
    busy_cnt = '0;
    be       = '0;
    wait_cnt = '0;
    cur_frame = '0;
    pending_frames.delete();
  endfunction

  function automatic void enter_cca();
    st       = ST_CCA;
    wait_cnt = (cfg_cca == 8'd0) ? 16'd1 : 16'(cfg_cca);
  endfunction

  function automatic void draw_backoff(logic [7:0] rnd);
    logic [7:0]  mask;
    int unsigned slots;
    // exponents of 8 and above keep every random bit
    mask  = (be >= 4'd8) ? 8'hFF : 8'((1 << be) - 1);
    slots = 32'(rnd & mask) * 32'(cfg_unit);
    if (slots == 0) begin
      enter_cca();
    end else begin
      st       = ST_BACKOFF;
      wait_cnt = 16'(slots);
    end
  endfunction

  function automatic void start_frame(cca_pkg::frame_t f, logic [7:0] rnd);
    cur_frame = f;
    busy_cnt  = '0;
    be        = cfg_min_be;
    draw_backoff(rnd);
  endfunction

  function automatic void start_next(logic [7:0] rnd);
    if (pending_frames.size() == 0) begin
      st        = ST_IDLE;
      wait_cnt  = '0;
      cur_frame = '0;
    end else begin
      start_frame(pending_frames.pop_front(), rnd);
    end
  endfunction

  function automatic void reset_predictor();
    cfg_min_be      = 4'd3;
    cfg_max_be      = 4'd5;
    cfg_retries     = 3'd4;
    cfg_cca         = 8'd8;
    cfg_unit        = 8'd20;
    cfg_tpb         = 4'd2;
    cfg_max_payload = 8'd100;
    cfg_radio       = 1'b1;
    flush_frames();
  endfunction

  function automatic void apply_reg_write(cca_pkg::reg_idx_e idx, logic [7:0] wdata);
    case (idx)
      cca_pkg::REG_MIN_BE:         cfg_min_be      = wdata[3:0];
      cca_pkg::REG_MAX_BE:         cfg_max_be      = wdata[3:0];
      cca_pkg::REG_MAX_RETRIES:    cfg_retries     = wdata[2:0];
      cca_pkg::REG_CCA_TICKS:      cfg_cca         = wdata;
      cca_pkg::REG_UNIT_TICKS:     cfg_unit        = wdata;
      cca_pkg::REG_TICKS_PER_BYTE: cfg_tpb         = wdata[3:0];
      cca_pkg::REG_MAX_PAYLOAD:    cfg_max_payload = wdata;
      default: begin
        cfg_radio = wdata[0];
        if (!wdata[0]) begin
          flush_frames();
        end
      end
    endcase
  endfunction

  function automatic void predict_item(cca_pkg::in_item_t it);
    cca_pkg::frame_t f;
    int unsigned     air;
    int unsigned     nb;
    if (it.opcode == cca_pkg::OP_SEND) begin
      f.dest  = it.broadcast ? cca_pkg::BCAST_DEST : it.dest_addr;
      f.bytes = 9'(cca_pkg::HEADER_BYTES + it.payload_bytes);
      if (!cfg_radio) begin
        push_event(cca_pkg::EV_RADIO_OFF, f, 4'd0);
      end else if (it.payload_bytes > cfg_max_payload) begin
        push_event(cca_pkg::EV_TOO_LONG, f, 4'd0);
      end else if (st == ST_IDLE) begin
        start_frame(f, it.random_bits);
      end else if (pending_frames.size() >= QUEUE_DEPTH) begin
        push_event(cca_pkg::EV_FULL, f, 4'd0);
      end else begin
        pending_frames.push_back(f);
      end
      return;
    end
    if (st == ST_IDLE) return;
    if (wait_cnt > 0) wait_cnt--;
    if (wait_cnt != 0) return;
    case (st)
      ST_BACKOFF: enter_cca();
      ST_CCA: begin
        if (it.channel_idle) begin
          push_event(cca_pkg::EV_TX_START, cur_frame, busy_cnt);
          air      = 32'(cur_frame.bytes) * 32'(cfg_tpb);
          st       = ST_TX;
          wait_cnt = (air == 0) ? 16'd1 : 16'(air);
        end else begin
          nb       = 32'(be) + 1;
          be       = (nb > cfg_max_be) ? cfg_max_be : 4'(nb);
          busy_cnt = busy_cnt + 4'd1;
          if (busy_cnt <= cfg_retries) begin
            draw_backoff(it.random_bits);
          end else begin
            push_event(cca_pkg::EV_ACCESS_FAIL, cur_frame, busy_cnt);
            start_next(it.random_bits);
          end
        end
      end
      default: begin
        push_event(cca_pkg::EV_RELEASE, cur_frame, busy_cnt);
        start_next(it.random_bits);
      end
    endcase
  endfunction

  // valid stays high into the next transaction when no gap is drawn
  task automatic send_item(cca_pkg::in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(it);
  endtask

  // requests cause no result, so give the pipeline time to empty as well
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cca_pkg::reg_idx_e idx, logic [7:0] wdata);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: wdata};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, wdata);
    @(posedge clk_i);
  endtask

  task automatic write_config(reg_set_t vals);
    int i;
    for (i = 0; i < 8; i++) begin
      write_reg(cca_pkg::reg_idx_e'(i), vals[i]);
    end
  endtask

  function automatic cca_pkg::in_item_t random_item(int unsigned send_pct,
                                                    bit short_payload,
                                                    int unsigned idle_pct);
    cca_pkg::in_item_t it;
    it.opcode        = ($urandom_range(99) < send_pct) ? cca_pkg::OP_SEND
                                                       : cca_pkg::OP_TICK;
    it.payload_bytes = (short_payload && $urandom_range(9) != 0) ?
                       8'($urandom_range(24)) : 8'($urandom);
    it.dest_addr     = 16'($urandom);
    it.broadcast     = ($urandom_range(7) == 0);
    it.channel_idle  = ($urandom_range(99) < idle_pct);
    it.random_bits   = 8'($urandom);
    return it;
  endfunction

  task automatic test_rejections();
    cca_pkg::in_item_t it;
    int i;
    it = '0;
    it.opcode = cca_pkg::OP_SEND;
    it.payload_bytes = 8'd101;
    send_item(it);
    it.payload_bytes = 8'hFF;
    it.broadcast     = 1'b1;
    it.dest_addr     = 16'h1234;
    send_item(it);
    // longest accepted payload starts at once on an idle block
    it.broadcast     = 1'b0;
    it.payload_bytes = 8'd100;
    it.dest_addr     = 16'hFFFF;
    it.random_bits   = 8'hFF;
    send_item(it);
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      it.payload_bytes = 8'(i);
      it.dest_addr     = 16'(i << 13);
      send_item(it);
    end
    it.payload_bytes = 8'd7;
    send_item(it);
    // too long is reported ahead of a full queue
    it.payload_bytes = 8'd101;
    send_item(it);
    it.opcode       = cca_pkg::OP_TICK;
    it.channel_idle = 1'b1;
    send_item(it);
    settle();
    write_reg(cca_pkg::REG_RADIO_ON, 8'h00);
    it.opcode        = cca_pkg::OP_SEND;
    it.payload_bytes = 8'hFF;
    send_item(it);
    it.opcode = cca_pkg::OP_TICK;
    send_item(it);
    settle();
    write_reg(cca_pkg::REG_RADIO_ON, 8'h01);
  endtask

  task automatic test_access_paths();
    cca_pkg::in_item_t it;
    reg_set_t          vals;
    settle();
    // min exponent above max, zero CCA time, zero airtime
    vals = '{8'd2, 8'd1, 8'd1, 8'd0, 8'd1, 8'd0, 8'd255, 8'd1};
    write_config(vals);
    it = '0;
    it.opcode        = cca_pkg::OP_SEND;
    it.payload_bytes = 8'hFF;
    it.dest_addr     = 16'h8001;
    send_item(it);
    it.payload_bytes = 8'd0;
    it.broadcast     = 1'b1;
    send_item(it);
    it.opcode       = cca_pkg::OP_TICK;
    it.channel_idle = 1'b0;
    it.random_bits  = 8'd1;
    send_item(it);
    send_item(it);
    // second busy CCA drops the frame; next one draws from this tick
    it.random_bits = 8'd0;
    send_item(it);
    it.channel_idle = 1'b1;
    send_item(it);
    send_item(it);
    send_item(it);
  endtask

  task automatic test_config_extremes();
    cca_pkg::in_item_t it;
    reg_set_t          vals;
    settle();
    vals = '{default: 8'h00};
    write_config(vals);
    it = '0;
    it.opcode        = cca_pkg::OP_SEND;
    it.payload_bytes = 8'd1;
    send_item(it);
    settle();
    write_reg(cca_pkg::REG_RADIO_ON, 8'h01);
    send_item(it);
    it.payload_bytes = 8'd0;
    it.dest_addr     = 16'h5555;
    it.random_bits   = 8'hFF;
    send_item(it);
    it.opcode = cca_pkg::OP_TICK;
    send_item(it);
    it.opcode    = cca_pkg::OP_SEND;
    it.broadcast = 1'b1;
    send_item(it);
    it.opcode       = cca_pkg::OP_TICK;
    it.channel_idle = 1'b1;
    send_item(it);
    send_item(it);
    settle();
    vals = '{default: 8'hFF};
    write_config(vals);
    it.opcode        = cca_pkg::OP_SEND;
    it.broadcast     = 1'b0;
    it.payload_bytes = 8'hFF;
    it.dest_addr     = 16'hAAAA;
    send_item(it);
    it.opcode = cca_pkg::OP_TICK;
    send_item(it);
    settle();
    write_reg(cca_pkg::REG_RADIO_ON, 8'h00);
  endtask

  task automatic test_random();
    int unsigned       counted;
    int unsigned       phase_len;
    int unsigned       kind;
    int unsigned       idle_pct;
    int unsigned       n;
    bit                was_wide;
    bit                short_pl;
    reg_set_t          vals;
    cca_pkg::in_item_t it;
    counted  = 0;
    was_wide = 1'b0;
    while (counted < TARGET_ITEMS) begin
      kind = $urandom_range(9);
      settle();
      if (was_wide) begin
        write_reg(cca_pkg::REG_RADIO_ON, 8'h00);
        write_reg(cca_pkg::REG_RADIO_ON, 8'h01);
      end
      was_wide = 1'b0;
      short_pl = 1'b1;
      idle_pct = $urandom_range(30, 95);
      if (kind == 0) begin
        // full-range settings, upper data bits included
        foreach (vals[i]) vals[i] = 8'($urandom);
        vals[cca_pkg::REG_RADIO_ON][0] = 1'b1;
        write_config(vals);
        was_wide  = 1'b1;
        short_pl  = 1'b0;
        phase_len = 60;
      end else if (kind == 1) begin
        write_reg(cca_pkg::REG_RADIO_ON, 8'($urandom) & 8'hFE);
        phase_len = 30;
      end else begin
        vals[cca_pkg::REG_MIN_BE]         = ($urandom_range(9) == 0) ?
                                            8'($urandom_range(15)) : 8'($urandom_range(4));
        vals[cca_pkg::REG_MAX_BE]         = ($urandom_range(9) == 0) ?
                                            8'($urandom_range(15)) : 8'($urandom_range(5));
        vals[cca_pkg::REG_MAX_RETRIES]    = 8'($urandom_range(7));
        vals[cca_pkg::REG_CCA_TICKS]      = 8'($urandom_range(3));
        vals[cca_pkg::REG_UNIT_TICKS]     = 8'($urandom_range(3));
        vals[cca_pkg::REG_TICKS_PER_BYTE] = 8'($urandom_range(2));
        vals[cca_pkg::REG_MAX_PAYLOAD]    = ($urandom_range(9) < 7) ?
                                            8'($urandom_range(30)) : 8'($urandom);
        vals[cca_pkg::REG_RADIO_ON]       = 8'd1;
        write_config(vals);
        phase_len = $urandom_range(120, 200);
      end
      no_idle = ($urandom_range(4) == 0);
      n = 0;
      while (n < phase_len) begin
        it = random_item((st == ST_IDLE) ? 50 : 8, short_pl, idle_pct);
        n++;
        send_item(it);
      end
      counted += n;
      no_idle = 1'b0;
    end
  endtask

  initial begin : result_check
    int unsigned        stall;
    cca_pkg::out_item_t got;
    cca_pkg::out_item_t want;
    logic               bad;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got = out_if.payload;
      if (expected_events.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: ev=%0d dest=%h bytes=%0d busy=%0d",
                   got.event_res, got.frame_dest, got.frame_bytes, got.busy_count);
        end
      end else begin
        want = expected_events.pop_front();
        bad  = (got.event_res !== want.event_res) || (got.frame_dest !== want.frame_dest) ||
               (got.frame_bytes !== want.frame_bytes) ||
               (got.busy_count !== want.busy_count);
        if (bad) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected ev=%0d dest=%h bytes=%0d busy=%0d",
                     want.event_res, want.frame_dest, want.frame_bytes, want.busy_count);
            $display("          got      ev=%0d dest=%h bytes=%0d busy=%0d",
                     got.event_res, got.frame_dest, got.frame_bytes, got.busy_count);
          end
        end
      end
    end
  end

  initial begin
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    rst_ni         <= 1'b0;
    reset_predictor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rejections();
    test_access_paths();
    test_config_extremes();
    test_random();
    in_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES * 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
